// ===== rtl/core/lrusr_pkg.sv =====
// Shared types and constants of the LRU set replacement tag store.
`timescale 1ns / 1ps
package lrusr_pkg;

   localparam int WAYS     = 8;
   localparam int SETS     = 256;
   localparam int TAG_BITS = 24;
   localparam int SET_BITS = 8;
   localparam int AGE_BITS = 3;
   localparam int CFG_BITS = 4;
   localparam int WAY_BITS = $clog2(WAYS);

   // Result codes.
   localparam logic [1:0] OUT_MISS_LOAD  = 2'd0;
   localparam logic [1:0] OUT_MISS_STORE = 2'd1;
   localparam logic [1:0] OUT_HIT_LOAD   = 2'd2;
   localparam logic [1:0] OUT_HIT_STORE  = 2'd3;
   localparam logic       STAT_OK        = 1'b0;
   localparam logic       STAT_BAD_WAYS  = 1'b1;

   // Register index, decoded from paddr[2].
   localparam logic       REG_WAYS_IN_USE = 1'b0;

   typedef struct packed {
      logic [SET_BITS-1:0] set_index;
      logic [TAG_BITS-1:0] tag;
      logic                is_store;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [1:0]          outcome;
      logic                victim_dirty;
      logic [TAG_BITS-1:0] evicted_tag;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

endpackage

// ===== rtl/core/lrusr_ctrl.sv =====
// Controller of the LRU set replacement tag store: issue read, then commit.
`timescale 1ns / 1ps
module lrusr_ctrl
   import lrusr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output ctl_cmd_type cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture  = 1'b0;
      cmd.commit   = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == ST_LOOKUP);
   assign rsp_valid = rsp_valid_ff;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && cmd.commit))
      else $error("accepted word did not enter lookup");

   a_lookup_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("lookup did not finish with a result strobe");

   a_strobe_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.commit))
      else $error("result strobe without a commit");

endmodule

// ===== rtl/core/lrusr_dpath.sv =====
// Datapath of the LRU set replacement tag store: set memory, lookup and update.
`timescale 1ns / 1ps
module lrusr_dpath
   import lrusr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   input  req_type             req_data,
   input  logic [CFG_BITS-1:0] ways_in_use,
   output rsp_type             rsp_data
);

   typedef struct packed {
      logic [WAYS-1:0]                valid;
      logic [WAYS-1:0]                dirty;
      logic [WAYS-1:0][TAG_BITS-1:0]  tag;
      logic [WAYS-1:0][AGE_BITS-1:0]  age;
   } row_type;

   row_type          set_mem_ff [SETS];
   logic [SETS-1:0]  row_vld_ff, row_vld_in;
   row_type          row_rd_ff;
   logic             row_hit_ff;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;

   row_type               eff;
   row_type               row_new;
   logic                  assoc_ok;
   logic [WAYS-1:0]       in_use;
   logic                  hit_found, free_found;
   logic [WAY_BITS-1:0]   hit_way, open_way, vict_way, fill_way;
   logic [AGE_BITS-1:0]   hit_age, mru;
   logic [CFG_BITS-1:0]   ways_m1;

   // A set never written reads as all lines invalid, clean and of age 0.
   always_comb begin
      eff = row_rd_ff;
      if (!row_hit_ff) begin
         eff.valid = '0;
         eff.dirty = '0;
         eff.age   = '0;
      end
   end

   assign ways_m1  = ways_in_use - CFG_BITS'(1);
   assign assoc_ok = (ways_in_use != '0) && (ways_in_use <= CFG_BITS'(WAYS))
                     && ((ways_in_use & ways_m1) == '0);
   assign mru      = ways_m1[AGE_BITS-1:0];

   // Scan the ways: the highest-numbered match, free way and age-0 way win.
   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_way    = '0;
      open_way   = '0;
      vict_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         in_use[w] = (CFG_BITS'(w) < ways_in_use);
         if (in_use[w] && eff.valid[w] && (eff.tag[w] == req_ff.tag)) begin
            hit_found = 1'b1;
            hit_way   = WAY_BITS'(w);
         end
         if (in_use[w] && !eff.valid[w]) begin
            free_found = 1'b1;
            open_way   = WAY_BITS'(w);
         end
         if (in_use[w] && (eff.age[w] == '0)) begin
            vict_way = WAY_BITS'(w);
         end
      end
   end

   assign hit_age  = eff.age[hit_way];
   assign fill_way = free_found ? open_way : vict_way;

   // Build the row to write back.
   always_comb begin
      row_new = eff;
      for (int w = 0; w < WAYS; w++) begin
         if (in_use[w] && (eff.age[w] != '0)) begin
            if (hit_found) begin
               if (eff.age[w] > hit_age) begin
                  row_new.age[w] = eff.age[w] - AGE_BITS'(1);
               end
            end else if (!free_found || eff.valid[w]) begin
               row_new.age[w] = eff.age[w] - AGE_BITS'(1);
            end
         end
      end
      if (hit_found) begin
         row_new.age[hit_way]   = mru;
         row_new.dirty[hit_way] = eff.dirty[hit_way] | req_ff.is_store;
      end else begin
         row_new.valid[fill_way] = 1'b1;
         row_new.dirty[fill_way] = req_ff.is_store;
         row_new.tag[fill_way]   = req_ff.tag;
         row_new.age[fill_way]   = mru;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (!assoc_ok) begin
         rsp_in.status = STAT_BAD_WAYS;
      end else begin
         if (hit_found) begin
            rsp_in.outcome = req_ff.is_store ? OUT_HIT_STORE : OUT_HIT_LOAD;
         end else begin
            rsp_in.outcome = req_ff.is_store ? OUT_MISS_STORE : OUT_MISS_LOAD;
            if (!free_found) begin
               rsp_in.victim_dirty = eff.dirty[vict_way];
               rsp_in.evicted_tag  = eff.tag[vict_way];
            end
         end
      end
   end

   always_comb begin
      row_vld_in = row_vld_ff;
      if (cmd.commit && assoc_ok) begin
         row_vld_in[req_ff.set_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         row_vld_ff <= row_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff     <= req_data;
         row_rd_ff  <= set_mem_ff[req_data.set_index];
         row_hit_ff <= row_vld_ff[req_data.set_index];
      end
      if (cmd.commit && assoc_ok) begin
         set_mem_ff[req_ff.set_index] <= row_new;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_bad_assoc_no_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !assoc_ok) |=> (row_vld_ff == $past(row_vld_ff)))
      else $error("set marked written under bad associativity");

   a_commit_marks_set: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && assoc_ok) |=> row_vld_ff[$past(req_ff.set_index)])
      else $error("committed set not marked written");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (hit_found || free_found)) |=> (rsp_data.evicted_tag == '0))
      else $error("eviction reported without a full-set miss");

endmodule

// ===== rtl/core/lru_set_replacement_top.sv =====
// Top level of the LRU set replacement tag store with its register port.
`timescale 1ns / 1ps
// Tag store of a 256-set, 8-way cache with per-line LRU ages.
// Request channel: drive req_data with start high; the word is taken at the
// edge where start is high and busy is low. busy is high for the one cycle
// that follows, while the set row read from memory is looked up and written
// back, so no new word is taken until the last is through the registered
// memory read and then the update and write-back.
// Response channel: rsp_valid rises at the edge after the accepting edge and
// is high for exactly one cycle, with status, outcome and any eviction in
// rsp_data. The receiver cannot hold results off; none is ever lost.
// Register port: ways_in_use at byte address 0, written with a setup and an
// access cycle; pready is always high. The user must write it only while no
// request is in flight; the block itself does not enforce this.
// Reset clears the controller, sets ways_in_use to 8 and marks every set
// unwritten at once, so every line reads invalid; no clearing pass is needed.
module lru_set_replacement_top
   import lrusr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [CFG_BITS-1:0] WAYS_RESET      = CFG_BITS'(8);

   logic [CFG_BITS-1:0] ways_ff, ways_in;
   ctl_cmd_type         cmd;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_WAYS_IN_USE);

   always_comb begin
      ways_in = ways_ff;
      if (csr_write) begin
         ways_in = pwdata[CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= WAYS_RESET;
      end else begin
         ways_ff <= ways_in;
      end
   end

   assign prdata = (paddr[2] == REG_WAYS_IN_USE) ? {{(32-CFG_BITS){1'b0}}, ways_ff} : '0;

   lrusr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lrusr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .ways_in_use (ways_ff),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== test/tb_lru_set_replacement_top.sv =====
// Self-checking testbench of the LRU set replacement tag store.
`timescale 1ns / 1ps
module tb_lru_set_replacement_top
   import lrusr_pkg::*;
();

   localparam int         LINES          = SETS * WAYS;
   localparam int         CYCLE_LIMIT    = 200000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_data  = '0;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [2:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;

   lru_set_replacement_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Shadow copy of the tag store and its register.
   logic                line_ok    [LINES];
   logic                line_dirty [LINES];
   logic [TAG_BITS-1:0] line_tag   [LINES];
   logic [AGE_BITS-1:0] line_age   [LINES];
   logic [CFG_BITS-1:0] cur_ways;

   rsp_type pending_rsp [$];
   rsp_type exp_rsp;
   int      mism = 0;
   int      n_checked = 0;
   int      n_hit = 0, n_miss = 0, n_evict = 0, n_dirty = 0, n_bad = 0, n_cfg = 0;
   int      cycles = 0;
   bit      idle_on = 1'b1;

   typedef struct {
      bit                  is_cfg;
      logic [CFG_BITS-1:0] ways;
      req_type             word;
      bit                  typed;
      rsp_type             want;
   } stim_row_type;

   stim_row_type rows [$];

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_rsp.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic rsp_type lookup_and_update(input req_type w);
      rsp_type             o;
      int                  a, base, hit, freew, victim, i;
      logic [AGE_BITS-1:0] mru, ha;
      o = '0;
      a = int'(cur_ways);
      if (a == 0 || a > WAYS || (a & (a - 1)) != 0) begin
         o.status = STAT_BAD_WAYS;
         return o;
      end
      base   = int'(w.set_index) * WAYS;
      mru    = AGE_BITS'(a - 1);
      hit    = -1;
      freew  = -1;
      victim = -1;
      for (i = 0; i < a; i++) begin
         if (line_ok[base+i] && line_tag[base+i] == w.tag) hit = i;
         if (!line_ok[base+i]) freew = i;
      end
      if (hit >= 0) begin
         o.outcome = w.is_store ? OUT_HIT_STORE : OUT_HIT_LOAD;
         ha = line_age[base+hit];
         // age only lines more recent than the hit, never below zero
         for (i = 0; i < a; i++) begin
            if (line_age[base+i] > ha && line_age[base+i] != 0)
               line_age[base+i] = line_age[base+i] - 1'b1;
         end
         line_age[base+hit] = mru;
         if (w.is_store) line_dirty[base+hit] = 1'b1;
         return o;
      end
      o.outcome = w.is_store ? OUT_MISS_STORE : OUT_MISS_LOAD;
      if (freew >= 0) begin
         for (i = 0; i < a; i++) begin
            if (line_ok[base+i] && line_age[base+i] != 0)
               line_age[base+i] = line_age[base+i] - 1'b1;
         end
         victim = freew;
      end else begin
         // last age-0 way goes; way 0 if stale ages left none
         for (i = 0; i < a; i++) begin
            if (line_age[base+i] == 0) victim = i;
            else line_age[base+i] = line_age[base+i] - 1'b1;
         end
         if (victim < 0) victim = 0;
         o.victim_dirty = line_dirty[base+victim];
         o.evicted_tag  = line_tag[base+victim];
      end
      line_ok[base+victim]    = 1'b1;
      line_dirty[base+victim] = w.is_store;
      line_tag[base+victim]   = w.tag;
      line_age[base+victim]   = mru;
      return o;
   endfunction

   function automatic req_type rand_word();
      req_type r;
      r.set_index = SET_BITS'($urandom);
      r.tag       = TAG_BITS'($urandom);
      r.is_store  = 1'($urandom);
      return r;
   endfunction

   task automatic add_cfg(input logic [CFG_BITS-1:0] v);
      stim_row_type r;
      r        = '{default: '0};
      r.is_cfg = 1'b1;
      r.ways   = v;
      rows.push_back(r);
   endtask

   task automatic add_acc(input logic [SET_BITS-1:0] s, input logic [TAG_BITS-1:0] t,
                          input logic st, input bit typed, input logic es,
                          input logic [1:0] eo, input logic ed,
                          input logic [TAG_BITS-1:0] et);
      stim_row_type r;
      r                   = '{default: '0};
      r.word.set_index    = s;
      r.word.tag          = t;
      r.word.is_store     = st;
      r.typed             = typed;
      r.want.status       = es;
      r.want.outcome      = eo;
      r.want.victim_dirty = ed;
      r.want.evicted_tag  = et;
      rows.push_back(r);
   endtask

   task automatic issue_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type p;
      while (idle_on && $urandom_range(99) < 28) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= rand_word();
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = lookup_and_update(w);
      if (p.status == STAT_BAD_WAYS) n_bad++;
      else if (p.outcome == OUT_HIT_LOAD || p.outcome == OUT_HIT_STORE) n_hit++;
      else begin
         n_miss++;
         // a clean eviction of tag zero goes uncounted here
         if (p.victim_dirty || p.evicted_tag != '0) n_evict++;
         if (p.victim_dirty) n_dirty++;
      end
      pending_rsp.push_back(typed ? want : p);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CFG_BITS-1:0] v);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_WAYS_IN_USE, 2'b00};
      pwdata  <= {28'($urandom), v};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cur_ways = v;
      n_cfg++;
      // read back on the same select
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[CFG_BITS-1:0] !== v) begin
         mism++;
         if (mism <= 10)
            $display("mismatch: ways_in_use read back exp %0d got %0d", v,
                     prdata[CFG_BITS-1:0]);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         n_checked++;
         if (pending_rsp.size() == 0) begin
            mism++;
            if (mism <= 10)
               $display("mismatch: result with none expected: status=%0d outcome=%0d",
                        rsp_data.status, rsp_data.outcome);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data !== exp_rsp) begin
               mism++;
               if (mism <= 10)
                  $display({"mismatch: exp status=%0d outcome=%0d dirty=%0d tag=%h, ",
                            "got status=%0d outcome=%0d dirty=%0d tag=%h"},
                           exp_rsp.status, exp_rsp.outcome, exp_rsp.victim_dirty,
                           exp_rsp.evicted_tag, rsp_data.status, rsp_data.outcome,
                           rsp_data.victim_dirty, rsp_data.evicted_tag);
            end
         end
      end
   end

   initial begin
      int          ways_seq [8];
      int          phase_len [8];
      int          ph, i, k;
      logic [7:0]  pool_set [3];
      logic [23:0] tag_base;
      req_type     w;

      ways_seq  = '{8, 4, 2, 1, 8, 6, 4, 8};
      phase_len = '{300, 250, 200, 150, 300, 40, 200, 200};
      for (k = 0; k < LINES; k++) begin
         line_ok[k]    = 1'b0;
         line_dirty[k] = 1'b0;
         line_tag[k]   = '0;
         line_age[k]   = '0;
      end
      cur_ways = CFG_BITS'(WAYS);

      // first rows run on the reset value of the register
      add_acc(8'd0,   24'h000000, 1'b0, 1, STAT_OK, OUT_MISS_LOAD,  1'b0, '0);
      add_acc(8'd0,   24'h000000, 1'b1, 1, STAT_OK, OUT_HIT_STORE,  1'b0, '0);
      add_acc(8'd255, 24'hFFFFFF, 1'b1, 1, STAT_OK, OUT_MISS_STORE, 1'b0, '0);
      add_acc(8'd255, 24'hFFFFFF, 1'b0, 1, STAT_OK, OUT_HIT_LOAD,   1'b0, '0);
      // fill set 1, first line dirty, then push it out
      add_acc(8'd1, 24'd1, 1'b1, 0, '0, '0, '0, '0);
      for (k = 2; k <= 8; k++) add_acc(8'd1, TAG_BITS'(k), 1'b0, 0, '0, '0, '0, '0);
      add_acc(8'd1, 24'd9,  1'b0, 1, STAT_OK, OUT_MISS_LOAD, 1'b1, 24'd1);
      add_acc(8'd1, 24'd10, 1'b1, 0, '0, '0, '0, '0);   // clean eviction
      add_acc(8'd1, 24'd5,  1'b1, 0, '0, '0, '0, '0);
      add_cfg(4'd3);
      add_acc(8'd0, 24'h000000, 1'b0, 1, STAT_BAD_WAYS, '0, 1'b0, '0);
      add_cfg(4'd0);
      add_acc(8'd7, 24'h00007B, 1'b1, 1, STAT_BAD_WAYS, '0, 1'b0, '0);
      add_cfg(4'd15);
      add_acc(8'd255, 24'hFFFFFF, 1'b1, 1, STAT_BAD_WAYS, '0, 1'b0, '0);
      add_cfg(4'd2);
      add_acc(8'd3, 24'h0ABCDE, 1'b0, 0, '0, '0, '0, '0);
      add_acc(8'd1, 24'd77,     1'b1, 0, '0, '0, '0, '0);  // stale ages, full set
      add_cfg(4'd1);
      add_acc(8'd3, 24'h0ABCDE, 1'b0, 0, '0, '0, '0, '0);
      add_cfg(4'd2);
      add_acc(8'd3, 24'h0ABCDE, 1'b1, 0, '0, '0, '0, '0);  // two matching ways
      add_cfg(4'd1);
      add_acc(8'd3, 24'h555555, 1'b1, 0, '0, '0, '0, '0);
      add_cfg(4'd4);
      add_acc(8'd1, 24'd1,   1'b0, 0, '0, '0, '0, '0);
      add_acc(8'd1, 24'd600, 1'b1, 0, '0, '0, '0, '0);
      add_cfg(4'd8);
      add_acc(8'd1, 24'd9,   1'b0, 0, '0, '0, '0, '0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         if (rows[r].is_cfg) begin
            drain_results();
            csr_write(rows[r].ways);
         end else begin
            issue_word(rows[r].word, rows[r].typed, rows[r].want);
         end
      end

      for (ph = 0; ph < 8; ph++) begin
         drain_results();
         csr_write(CFG_BITS'(ways_seq[ph]));
         idle_on  = (ph != 4);
         tag_base = TAG_BITS'($urandom);
         for (k = 0; k < 3; k++) pool_set[k] = SET_BITS'($urandom);
         for (i = 0; i < phase_len[ph]; i++) begin
            // hold off once mid-phase until every result is in
            if (ph == 0 && i == 150) drain_results();
            w = rand_word();
            if ($urandom_range(99) < 75) begin
               w.set_index = pool_set[$urandom_range(2)];
               w.tag       = tag_base ^ TAG_BITS'($urandom_range(ways_seq[ph] + 3));
            end
            issue_word(w, 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (pending_rsp.size() != 0) mism += pending_rsp.size();

      $display("covered %0d results over %0d register settings: %0d hits, %0d misses",
               n_checked, n_cfg, n_hit, n_miss);
      $display("evictions %0d (%0d dirty), bad associativity %0d, mismatches %0d",
               n_evict, n_dirty, n_bad, mism);
      if (mism == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
